[design/dasd_pkg.sv]
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared types, constants and calendar helper functions for the date shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package dasd_pkg;

  localparam logic [13:0] YEAR_CYCLE    = 14'd400;  // Gregorian cycle length
  localparam logic [2:0]  MOD_STEP_LAST = 3'd5;     // 400 << 5 still fits 14 bits
  localparam logic [8:0]  Y400_LAST     = 9'd399;
  localparam logic [8:0]  DAYS_YEAR     = 9'd365;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [3:0]  MONTH_FIRST   = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_LAST    = 4'd12;
  localparam logic        OP_ADD        = 1'b0;
  localparam logic        OP_SUB        = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic year_step;
    logic month_step;
    logic out_load;
  } dasd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic mod_last;
    logic date_ok;
    logic year_done;
    logic year_err;
    logic month_done;
    logic out_free;
  } dasd_status_t;

  // Leap year from the year's position within its 400-year cycle.
  function automatic logic leap_of(input logic [8:0] y400);
    logic by4;
    logic century;
    by4     = (y400[1:0] == 2'd0);
    century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return by4 && !century;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a year.
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Subtrahend for one step of the year mod 400 reduction.
  function automatic logic [13:0] mod_step_val(input logic [2:0] k);
    return YEAR_CYCLE << k;
  endfunction

endpackage

`default_nettype wire

[design/dasd_in_if.sv]
// ----------------------------------------------------------------------------
// dasd_in_if
// Input channel: one date, a day count and an add/subtract opcode per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dasd_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;
  logic [15:0] day_count;
  logic        opcode;

  modport source (
    output valid, start_day, start_month, start_year, day_count, opcode,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year, day_count, opcode,
    output ready
  );
endinterface

`default_nettype wire

[design/dasd_out_if.sv]
// ----------------------------------------------------------------------------
// dasd_out_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dasd_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic        leap_year;
  logic [8:0]  day_of_year;
  logic [4:0]  result_day;
  logic [3:0]  result_month;
  logic [13:0] result_year;
  logic        range_error;

  modport source (
    output valid, date_valid, leap_year, day_of_year, result_day, result_month,
           result_year, range_error,
    input  ready
  );
  modport sink (
    input  valid, date_valid, leap_year, day_of_year, result_day, result_month,
           result_year, range_error,
    output ready
  );
endinterface

`default_nettype wire

[design/date_add_subtract_days_top.sv]
// ----------------------------------------------------------------------------
// date_add_subtract_days_top
// Gregorian date checker and day-count shifter.
// ----------------------------------------------------------------------------
// Each input item holds a day, month and year, a day count and an opcode
// (add or subtract). The block returns one result item: whether the date is
// a real Gregorian date in years 1..YEAR_MAX, the leap flag of the input
// year, the day of year, and the date moved by the low COUNT_BITS bits of
// the count. A move past 1 Jan of year 1 or 31 Dec of YEAR_MAX sets
// range_error and zeroes the result date; an invalid date zeroes everything
// but the leap flag. Items are handled one at a time: the block accepts the
// item, reduces the year mod 400, checks the date, then walks the years one
// boundary per step with one more step that settles the year, walks the
// months and loads the output register. An invalid date skips both walks,
// and the year-by-year walk makes the run time grow with the years crossed.
// The output register frees the input side as soon as a result is loaded,
// so the next item is worked on while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module date_add_subtract_days_top #(
  parameter int YEAR_MAX   = 9999,
  parameter int COUNT_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dasd_in_if.sink    in_i,
  dasd_out_if.source out_o
);

  dasd_pkg::dasd_cmd_t    cmd;     // sequencer -> datapath
  dasd_pkg::dasd_status_t status;  // datapath -> sequencer
  logic                   in_ready;

  assign in_i.ready = in_ready;

  dasd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dasd_datapath #(
    .YEAR_MAX   (YEAR_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .start_day_i    (in_i.start_day),
    .start_month_i  (in_i.start_month),
    .start_year_i   (in_i.start_year),
    .day_count_i    (in_i.day_count),
    .opcode_i       (in_i.opcode),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .date_valid_o   (out_o.date_valid),
    .leap_year_o    (out_o.leap_year),
    .day_of_year_o  (out_o.day_of_year),
    .result_day_o   (out_o.result_day),
    .result_month_o (out_o.result_month),
    .result_year_o  (out_o.result_year),
    .range_error_o  (out_o.range_error)
  );

endmodule

`default_nettype wire

[design/dasd_datapath.sv]
// ----------------------------------------------------------------------------
// dasd_datapath
// Year reduction, date check, year-by-year and month-by-month carry walk,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dasd_datapath #(
  parameter int YEAR_MAX   = 9999,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dasd_pkg::dasd_cmd_t   cmd_i,
  output dasd_pkg::dasd_status_t     status_o,
  input  wire logic [4:0]            start_day_i,
  input  wire logic [3:0]            start_month_i,
  input  wire logic [13:0]           start_year_i,
  input  wire logic [15:0]           day_count_i,
  input  wire logic                  opcode_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic                       date_valid_o,
  output logic                       leap_year_o,
  output logic [8:0]                 day_of_year_o,
  output logic [4:0]                 result_day_o,
  output logic [3:0]                 result_month_o,
  output logic [13:0]                result_year_o,
  output logic                       range_error_o
);

  localparam int YW_NEED = $clog2(YEAR_MAX + 1);
  localparam int YW      = (YW_NEED > 14) ? YW_NEED : 14;
  localparam int CB      = COUNT_BITS;
  localparam int TW      = ((CB > 9) ? CB : 9) + 1;
  localparam logic [YW-1:0] YearMax = YW'(YEAR_MAX);
  localparam logic [YW-1:0] YearOne = YW'(1);

  // Latched item
  logic [4:0]    day_q;
  logic [3:0]    month_q;
  logic [13:0]   year_in_q;
  logic [CB-1:0] count_q;
  logic          sub_q;
  // Working state
  logic [13:0]   mod_q;
  logic [2:0]    step_q;
  logic [YW-1:0] year_q;
  logic [8:0]    y400_q;
  logic [TW-1:0] days_q;
  logic [CB-1:0] rem_q;
  logic          valid_q;
  logic          leap_q;
  logic [8:0]    doy_q;
  logic          err_q;
  // Output register
  logic          out_valid_q;
  logic          out_date_valid_q;
  logic          out_leap_q;
  logic [8:0]    out_doy_q;
  logic [4:0]    out_day_q;
  logic [3:0]    out_month_q;
  logic [13:0]   out_year_q;
  logic          out_err_q;

  logic [13:0]   mod_sub;
  logic          leap_in;
  logic [4:0]    mlen_in;
  logic          date_ok;
  logic [8:0]    doy_in;
  logic          leap_cur;
  logic [8:0]    year_len;
  logic [8:0]    y400_inc;
  logic [8:0]    y400_dec;
  logic [8:0]    prev_len;
  logic          add_fits;
  logic          sub_fits;
  logic          year_done;
  logic          year_err;
  logic [4:0]    mlen_cur;
  logic          month_done;
  logic          res_ok;

  always_comb begin
    mod_sub  = dasd_pkg::mod_step_val(step_q);
    leap_in  = dasd_pkg::leap_of(mod_q[8:0]);
    mlen_in  = dasd_pkg::month_len(month_q, leap_in);
    date_ok  = (YW'(year_in_q) >= YearOne) && (YW'(year_in_q) <= YearMax) &&
               (month_q >= dasd_pkg::MONTH_FIRST) && (month_q <= dasd_pkg::MONTH_LAST) &&
               (day_q != 5'd0) && (day_q <= mlen_in);
    doy_in   = dasd_pkg::days_before_month(month_q, leap_in) + 9'(day_q);

    leap_cur = dasd_pkg::leap_of(y400_q);
    year_len = leap_cur ? dasd_pkg::DAYS_LEAP : dasd_pkg::DAYS_YEAR;
    y400_inc = (y400_q == dasd_pkg::Y400_LAST) ? 9'd0 : y400_q + 9'd1;
    y400_dec = (y400_q == 9'd0) ? dasd_pkg::Y400_LAST : y400_q - 9'd1;
    prev_len = dasd_pkg::leap_of(y400_dec) ? dasd_pkg::DAYS_LEAP : dasd_pkg::DAYS_YEAR;

    add_fits  = (days_q <= TW'(year_len));
    sub_fits  = (TW'(rem_q) < days_q);
    year_done = (sub_q == dasd_pkg::OP_SUB) ? sub_fits : add_fits;
    year_err  = !year_done &&
                ((sub_q == dasd_pkg::OP_SUB) ? (year_q == YearOne) : (year_q == YearMax));

    mlen_cur   = dasd_pkg::month_len(month_q, leap_cur);
    month_done = (month_q == dasd_pkg::MONTH_LAST) || (days_q <= TW'(mlen_cur));

    res_ok = valid_q && !err_q;
  end

  assign status_o.mod_last   = (step_q == 3'd0);
  assign status_o.date_ok    = date_ok;
  assign status_o.year_done  = year_done;
  assign status_o.year_err   = year_err;
  assign status_o.month_done = month_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q     <= start_day_i;
      month_q   <= start_month_i;
      year_in_q <= start_year_i;
      count_q   <= CB'(day_count_i);
      sub_q     <= opcode_i;
      mod_q     <= start_year_i;
      step_q    <= dasd_pkg::MOD_STEP_LAST;
    end
    if (cmd_i.mod_step) begin
      if (mod_q >= mod_sub) begin
        mod_q <= mod_q - mod_sub;
      end
      step_q <= step_q - 3'd1;
    end
    if (cmd_i.check) begin
      valid_q <= date_ok;
      leap_q  <= leap_in;
      doy_q   <= date_ok ? doy_in : 9'd0;
      err_q   <= 1'b0;
      year_q  <= YW'(year_in_q);
      y400_q  <= mod_q[8:0];
      rem_q   <= count_q;
      month_q <= dasd_pkg::MONTH_FIRST;
      days_q  <= (sub_q == dasd_pkg::OP_SUB) ? TW'(doy_in) : TW'(doy_in) + TW'(count_q);
    end
    if (cmd_i.year_step) begin
      if (year_done) begin
        if (sub_q == dasd_pkg::OP_SUB) begin
          days_q <= days_q - TW'(rem_q);
        end
      end else if (year_err) begin
        err_q <= 1'b1;
      end else if (sub_q == dasd_pkg::OP_SUB) begin
        // step back to Dec 31 of the previous year
        rem_q  <= rem_q - CB'(days_q);
        year_q <= year_q - YearOne;
        y400_q <= y400_dec;
        days_q <= TW'(prev_len);
      end else begin
        days_q <= days_q - TW'(year_len);
        year_q <= year_q + YearOne;
        y400_q <= y400_inc;
      end
    end
    if (cmd_i.month_step && !month_done) begin
      days_q  <= days_q - TW'(mlen_cur);
      month_q <= month_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_date_valid_q <= valid_q;
      out_leap_q       <= leap_q;
      out_doy_q        <= doy_q;
      out_day_q        <= res_ok ? days_q[4:0] : 5'd0;
      out_month_q      <= res_ok ? month_q : 4'd0;
      out_year_q       <= res_ok ? year_q[13:0] : 14'd0;
      out_err_q        <= valid_q && err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign date_valid_o   = out_date_valid_q;
  assign leap_year_o    = out_leap_q;
  assign day_of_year_o  = out_doy_q;
  assign result_day_o   = out_day_q;
  assign result_month_o = out_month_q;
  assign result_year_o  = out_year_q;
  assign range_error_o  = out_err_q;

  // Year walk stays inside the legal year range.
  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.year_step |-> (year_q >= YearOne) && (year_q <= YearMax) &&
                        (y400_q <= dasd_pkg::Y400_LAST))
    else $error("year walk left the legal range");

  // Month walk only sees real months.
  a_month_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.month_step |-> (month_q >= dasd_pkg::MONTH_FIRST) &&
                         (month_q <= dasd_pkg::MONTH_LAST))
    else $error("month walk out of range");

  // A range error only follows a valid date and carries a zero date.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_date_valid_q && (out_day_q == 5'd0) &&
                                   (out_month_q == 4'd0) && (out_year_q == 14'd0))
    else $error("range error with inconsistent result fields");

endmodule

`default_nettype wire

[design/dasd_ctrl.sv]
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer: accept, reduce year, check date, walk years, walk months, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module dasd_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire dasd_pkg::dasd_status_t status_i,
  output dasd_pkg::dasd_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_CHECK = 6'b000100,
    S_YEAR  = 6'b001000,
    S_MONTH = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.date_ok ? S_YEAR : S_DONE;
      end
      S_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (status_i.year_done) begin
          state_d = S_MONTH;
        end else if (status_i.year_err) begin
          state_d = S_DONE;
        end
      end
      S_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (status_i.month_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item always starts the year reduction.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MOD))
    else $error("accepted item did not start processing");

  // A finished result waits while the output register is still occupied.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !status_i.out_free) |=> (state_q == S_DONE))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

[sim/dasd_shift_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_shift_checker
// Watches both channels of the date shifter, predicts each result from the
// accepted item and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module dasd_shift_checker #(
  parameter int YEAR_MAX   = 9999,
  parameter int COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dasd_in_if   in_mon,
  dasd_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int PRINT_MAX = 20;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] count;
    logic        op;
  } shift_request_t;

  typedef struct packed {
    logic        date_valid;
    logic        leap_year;
    logic [8:0]  day_of_year;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        range_error;
  } shift_answer_t;

  shift_answer_t expected_dates[$];
  int            results_seen = 0;

  function automatic bit leap_rule(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit lp);
    int unsigned n;
    case (m)
      4, 6, 9, 11: n = 30;
      2:           n = lp ? 29 : 28;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // Day number of 31 Dec of year y-1, counting 1 Jan of year 1 as day 1.
  function automatic int unsigned days_ahead_of_year(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic shift_answer_t shift_date(input shift_request_t rq);
    shift_answer_t a;
    int unsigned   d, m, y, cnt, doy, serial, last_serial, s, yr, rem, mo;
    bit            lp, yr_leap, ok, out_of_range;
    a   = '0;
    d   = rq.day;
    m   = rq.month;
    y   = rq.year;
    cnt = int'(rq.count) & ((32'd1 << COUNT_BITS) - 1);
    lp  = leap_rule(y);
    ok  = (y >= 1) && (y <= YEAR_MAX) && (m >= 1) && (m <= 12) &&
          (d >= 1) && (d <= month_days(m, lp));
    a.leap_year  = lp;
    a.date_valid = ok;
    if (ok) begin
      doy = d;
      for (mo = 1; mo < m; mo++) begin
        doy += month_days(mo, lp);
      end
      a.day_of_year = doy[8:0];
      serial      = days_ahead_of_year(y) + doy;
      last_serial = days_ahead_of_year(YEAR_MAX + 1);
      if (rq.op == dasd_pkg::OP_SUB) begin
        out_of_range = (cnt >= serial);
        s = serial - cnt;
      end else begin
        s = serial + cnt;
        out_of_range = (s > last_serial);
      end
      if (out_of_range) begin
        a.range_error = 1'b1;
      end else begin
        // a year never has more than 366 days, so this starts at or below
        yr = (s - 1) / 366 + 1;
        while (days_ahead_of_year(yr + 1) < s) begin
          yr++;
        end
        rem     = s - days_ahead_of_year(yr);
        yr_leap = leap_rule(yr);
        mo      = 1;
        while ((mo < 12) && (rem > month_days(mo, yr_leap))) begin
          rem -= month_days(mo, yr_leap);
          mo++;
        end
        a.result_day   = rem[4:0];
        a.result_month = mo[3:0];
        a.result_year  = yr[13:0];
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= PRINT_MAX) begin
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    end
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin : watch
    shift_answer_t  got, want;
    shift_request_t rq;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        got.date_valid   = out_mon.date_valid;
        got.leap_year    = out_mon.leap_year;
        got.day_of_year  = out_mon.day_of_year;
        got.result_day   = out_mon.result_day;
        got.result_month = out_mon.result_month;
        got.result_year  = out_mon.result_year;
        got.range_error  = out_mon.range_error;
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_dates.pop_front();
          check_field("date_valid", 32'(got.date_valid), 32'(want.date_valid));
          check_field("leap_year", 32'(got.leap_year), 32'(want.leap_year));
          check_field("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year));
          check_field("result_day", 32'(got.result_day), 32'(want.result_day));
          check_field("result_month", 32'(got.result_month),
                      32'(want.result_month));
          check_field("result_year", 32'(got.result_year), 32'(want.result_year));
          check_field("range_error", 32'(got.range_error), 32'(want.range_error));
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        rq.day   = in_mon.start_day;
        rq.month = in_mon.start_month;
        rq.year  = in_mon.start_year;
        rq.count = in_mon.day_count;
        rq.op    = in_mon.opcode;
        expected_dates.push_back(shift_date(rq));
      end
      pending_o = expected_dates.size();
    end
  end

endmodule

[sim/tb_date_add_subtract_days_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_add_subtract_days_top
// Drives dates, day counts and add/subtract items into the date shifter.
// A directed set hits the calendar edges, then a few hundred random items
// follow, mostly real dates with random counts and some raw noise. The
// sender idles in bursts, the receiver stalls on its own pattern and once
// holds off long enough to back the block up. The checker does the rest.
// ----------------------------------------------------------------------------

module tb_date_add_subtract_days_top;

  localparam int YEAR_MAX     = 9999;
  localparam int COUNT_BITS   = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int HOLD_AFTER   = 120;    // items sent before the hold-off
  localparam int TAIL_CYCLES  = 300;    // longer than one full-count walk
  localparam int CYCLE_LIMIT  = 800000;

  logic clk_i;
  logic rst_ni;

  dasd_in_if  in_bus ();
  dasd_out_if out_bus ();

  int fail_count;
  int pending;
  int items_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  bit hold_done   = 1'b0;

  date_add_subtract_days_top #(
    .YEAR_MAX   (YEAR_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  dasd_shift_checker #(
    .YEAR_MAX   (YEAR_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog. The limit stays well above the run of all items at full-count
  // walks plus stalls, gaps and the hold-off.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one item and wait for it to be taken. Gaps open only between
  // bursts, so valid never drops inside a burst.
  task automatic send_date(input logic [4:0] d, input logic [3:0] m,
                           input logic [13:0] y, input logic [15:0] cnt,
                           input logic op);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.start_day   <= d;
    in_bus.start_month <= m;
    in_bus.start_year  <= y;
    in_bus.day_count   <= cnt;
    in_bus.opcode      <= op;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
  endtask

  // Receiver: ready runs of random length, stalls of random length,
  // and one long hold-off while the sender keeps offering.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && (items_sent >= HOLD_AFTER)) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          kind;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [15:0] cnt;
    logic        op;

    in_bus.valid       = 1'b0;
    in_bus.start_day   = '0;
    in_bus.start_month = '0;
    in_bus.start_year  = '0;
    in_bus.day_count   = '0;
    in_bus.opcode      = dasd_pkg::OP_ADD;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: calendar edges ---
    send_date(5'd1,  4'd1,  14'd1,     16'd0,     dasd_pkg::OP_ADD);  // first day
    send_date(5'd1,  4'd1,  14'd1,     16'd1,     dasd_pkg::OP_SUB);  // before year 1
    send_date(5'd1,  4'd1,  14'd1,     16'd0,     dasd_pkg::OP_SUB);
    send_date(5'd2,  4'd1,  14'd2,     16'd366,   dasd_pkg::OP_SUB);  // to 1 Jan 1
    send_date(5'd1,  4'd1,  14'd1,     16'hFFFF,  dasd_pkg::OP_ADD);  // full count fwd
    send_date(5'd31, 4'd12, 14'd9999,  16'd1,     dasd_pkg::OP_ADD);  // past last day
    send_date(5'd31, 4'd12, 14'd9999,  16'd0,     dasd_pkg::OP_ADD);
    send_date(5'd30, 4'd12, 14'd9999,  16'd2,     dasd_pkg::OP_ADD);
    send_date(5'd31, 4'd12, 14'd9998,  16'd365,   dasd_pkg::OP_ADD);  // the last day
    send_date(5'd31, 4'd12, 14'd9999,  16'hFFFF,  dasd_pkg::OP_SUB);  // full count back
    // leap rules: by 400, by 100, by 4, plain year
    send_date(5'd29, 4'd2,  14'd2000,  16'd365,   dasd_pkg::OP_ADD);
    send_date(5'd29, 4'd2,  14'd1900,  16'd1,     dasd_pkg::OP_ADD);  // not a date
    send_date(5'd29, 4'd2,  14'd2024,  16'd366,   dasd_pkg::OP_SUB);
    send_date(5'd29, 4'd2,  14'd2023,  16'd1,     dasd_pkg::OP_ADD);  // not a date
    send_date(5'd28, 4'd2,  14'd2100,  16'd1,     dasd_pkg::OP_ADD);  // to 1 Mar 2100
    send_date(5'd1,  4'd3,  14'd2000,  16'd1,     dasd_pkg::OP_SUB);  // to 29 Feb
    send_date(5'd31, 4'd12, 14'd1999,  16'd1,     dasd_pkg::OP_ADD);  // year carry
    // malformed fields
    send_date(5'd1,  4'd1,  14'd0,     16'd10,    dasd_pkg::OP_ADD);  // year zero
    send_date(5'd0,  4'd5,  14'd2020,  16'd10,    dasd_pkg::OP_ADD);  // day zero
    send_date(5'd15, 4'd0,  14'd2020,  16'd10,    dasd_pkg::OP_SUB);  // month zero
    send_date(5'd15, 4'd13, 14'd2020,  16'd10,    dasd_pkg::OP_ADD);
    send_date(5'd31, 4'd15, 14'h3FFF,  16'hFFFF,  dasd_pkg::OP_SUB);  // all bits high
    send_date(5'd31, 4'd4,  14'd2021,  16'd1,     dasd_pkg::OP_ADD);  // 31 April
    send_date(5'd1,  4'd1,  14'd10000, 16'd1,     dasd_pkg::OP_ADD);  // past the max

    // --- random ---
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // mostly real dates; days 29..31 sometimes miss and become noise
        case ($urandom_range(0, 9))
          0:       y = 14'($urandom_range(1, 3));
          1:       y = 14'($urandom_range(YEAR_MAX - 4, YEAR_MAX));
          default: y = 14'($urandom_range(1, YEAR_MAX));
        endcase
        m = 4'($urandom_range(1, 12));
        d = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(27, 31))
                                        : 5'($urandom_range(1, 28));
        case ($urandom_range(0, 6))
          0, 1, 2: cnt = 16'($urandom_range(0, 400));
          3, 4:    cnt = 16'($urandom);
          5:       cnt = 16'($urandom_range(60000, 65535));
          default: cnt = 16'($urandom_range(0, 3));
        endcase
        op = ($urandom_range(0, 1) == 0) ? dasd_pkg::OP_ADD : dasd_pkg::OP_SUB;
      end else begin
        d   = 5'($urandom);
        m   = 4'($urandom);
        y   = 14'($urandom);
        cnt = 16'($urandom);
        op  = ($urandom_range(0, 1) == 0) ? dasd_pkg::OP_ADD : dasd_pkg::OP_SUB;
      end
      send_date(d, m, y, cnt, op);
    end

    in_bus.valid <= 1'b0;
    // one edge so the checker has booked the last item
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dasd_pkg.sv
design/dasd_in_if.sv
design/dasd_out_if.sv
design/dasd_datapath.sv
design/dasd_ctrl.sv
design/date_add_subtract_days_top.sv
sim/dasd_shift_checker.sv
sim/tb_date_add_subtract_days_top.sv
